### rtl/sfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, widths and helpers for the sphere/frustum cull and LOD block.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int DEF_ID_BITS   = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CFG_IDX_W = 3;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;

    typedef enum logic [1:0] {
        MODE_ROW0,
        MODE_ROW1,
        MODE_ROW2,
        MODE_SPHERE
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] val_a;
        logic signed [31:0] val_b;
        logic signed [31:0] val_c;
        logic signed [31:0] val_d;
        logic [15:0]        object_id;
    } item_t;

    typedef struct packed {
        logic [15:0] visible_id;
        logic [1:0]  lod_level;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff}))
            return 32'sh7fff_ffff;
        else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000}))
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/sphere_frustum_cull_lod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_frustum_cull_lod
// Bounding-sphere frustum cull with depth-based level of detail, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  cfg channel (valid/ready): eight 64-bit view-projection registers. Each
//  write rebuilds the six normalized planes, Q16.16 at default FRAC_BITS;
//  cfg_ready and the item channel are held off meanwhile. The same rebuild
//  runs after reset.
//  item channel (valid/stall): mode 0..2 loads one model row with no result.
//  Mode 3 is a sphere: world transform, scale square root, bound, then plane
//  tests that stop early once it is culled, then depth and emit if visible,
//  all on one shared multiplier and one iterative square root unit.
//  A culled sphere gives no result; a visible one transfers id and LOD on the
//  result channel.
//  result channel (valid/stall): one output register. The next item is taken
//  while a result waits; a finished sphere waits for the register to free up.
//  Reset: identity matrix, zero model rows, no result pending.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_lod
    import sfc_pkg::*;
#(
    parameter int ID_BITS   = DEF_ID_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam int DVD_W = 32 + FRAC_BITS;
    localparam logic signed [31:0] ONE    = 32'(1) << FRAC_BITS;
    localparam logic signed [39:0] LOD_T1 = 40'sd25 << FRAC_BITS;
    localparam logic signed [39:0] LOD_T2 = 40'sd100 << FRAC_BITS;
    localparam logic signed [39:0] LOD_T3 = 40'sd250 << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD_SQ,
        S_BUILD_SQRT,
        S_BUILD_DIV,
        S_WORLD,
        S_SCALE_SQ,
        S_SCALE_SQRT,
        S_BOUND,
        S_PLANE,
        S_DEPTH,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         k_reg, k_next;
    logic [1:0]         c_reg, c_next;
    logic               ph_reg, ph_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic [63:0]        vp_reg [8];
    logic signed [31:0] mrow_reg [12];
    logic signed [31:0] plane_reg [24];
    logic signed [31:0] wc_reg [3];
    logic signed [31:0] sph_reg [4];
    logic [15:0]        id_reg;
    logic [31:0]        len_reg;
    logic [31:0]        scale_reg;
    logic signed [31:0] bound_reg;
    logic [1:0]         lod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [31:0] vp_m [4][4];
    logic signed [32:0] raw_sum;
    logic signed [31:0] praw;
    logic [31:0]        pmag;
    logic signed [31:0] wc_sel;
    logic signed [OPND_W-1:0] opnd_a, opnd_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term, acc_base, acc_init, acc_sum;
    logic signed [31:0] s_sat;
    logic signed [32:0] neg_bound;
    logic               culled;
    logic signed [39:0] dz;
    logic [1:0]         lod_calc;
    logic [15:0]        id_mask;
    logic               sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic               div_start, div_done;
    logic [DVD_W-1:0]   div_quot;
    logic               quot_ovf;
    logic signed [31:0] norm;

    logic               acc_we, wc_we, len_we, scale_we, bound_we;
    logic               plane_we, lod_we, sph_we, row_we, cfg_we;
    logic signed [31:0] plane_wdata;

    // ---- operand decode ----
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                vp_m[r][c] = vp_reg[r * 2 + c / 2][32 * (c % 2) +: 32];
    end

    // row3 +/- row k/2 of the view-projection matrix
    assign raw_sum = k_reg[0] ? (33'(vp_m[3][c_reg]) - 33'(vp_m[k_reg[2:1]][c_reg]))
                              : (33'(vp_m[3][c_reg]) + 33'(vp_m[k_reg[2:1]][c_reg]));
    assign praw    = sat32(ACC_W'(raw_sum));
    assign pmag    = praw[31] ? 32'(-praw) : praw;

    always_comb
    begin
        case (c_reg)
            2'd0:    wc_sel = wc_reg[0];
            2'd1:    wc_sel = wc_reg[1];
            2'd2:    wc_sel = wc_reg[2];
            default: wc_sel = ONE;
        endcase
    end

    always_comb
    begin
        opnd_a = '0;
        opnd_b = '0;
        case (state_reg)
            S_BUILD_SQ:
            begin
                opnd_a = OPND_W'(praw);
                opnd_b = OPND_W'(praw);
            end
            S_WORLD:
            begin
                opnd_a = OPND_W'(mrow_reg[{k_reg[1:0], c_reg}]);
                opnd_b = OPND_W'(sph_reg[c_reg]);
            end
            S_SCALE_SQ:
            begin
                opnd_a = OPND_W'(mrow_reg[{c_reg, 2'd0}]);
                opnd_b = OPND_W'(mrow_reg[{c_reg, 2'd0}]);
            end
            S_BOUND:
            begin
                opnd_a = OPND_W'(sph_reg[3]);
                opnd_b = $signed({1'b0, scale_reg});
            end
            S_PLANE:
            begin
                opnd_a = OPND_W'(plane_reg[{k_reg, c_reg}]);
                opnd_b = OPND_W'(wc_sel);
            end
            S_DEPTH:
            begin
                opnd_a = OPND_W'(vp_m[2][c_reg]);
                opnd_b = OPND_W'(wc_sel);
            end
            default:
            begin
                opnd_a = '0;
                opnd_b = '0;
            end
        endcase
    end

    sfc_mul u_mul (
        .clk    (clk),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .prod   (prod)
    );

    sfc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    sfc_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({pmag, {FRAC_BITS{1'b0}}}),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // squares are summed raw, all other products are floored fixed point
    assign term = (state_reg == S_BUILD_SQ || state_reg == S_SCALE_SQ)
                ? ACC_W'(prod) : ACC_W'(prod >>> FRAC_BITS);
    assign acc_init  = (state_reg == S_WORLD) ? ACC_W'(mrow_reg[{k_reg[1:0], 2'd3}]) : '0;
    assign acc_base  = (c_reg == 2'd0) ? acc_init : acc_reg;
    assign acc_sum   = acc_base + term;
    assign s_sat     = sat32(acc_sum);
    assign neg_bound = -(33'(bound_reg));
    assign culled    = (33'(s_sat) < neg_bound);

    assign quot_ovf = |div_quot[DVD_W-1:31];
    always_comb
    begin
        if (praw[31])
            norm = quot_ovf ? 32'sh8000_0000 : -$signed(div_quot[31:0]);
        else
            norm = quot_ovf ? 32'sh7fff_ffff : $signed(div_quot[31:0]);
    end

    assign dz = 40'(s_sat) - 40'(sph_reg[3]);
    always_comb
    begin
        if (dz >= LOD_T3)
            lod_calc = 2'd3;
        else if (dz >= LOD_T2)
            lod_calc = 2'd2;
        else if (dz >= LOD_T1)
            lod_calc = 2'd1;
        else
            lod_calc = 2'd0;
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            id_mask[i] = (i < ID_BITS);
    end

    // ---- sequencer ----
    always_comb
    begin
        logic col_done;
        col_done          = 1'b0;
        state_next        = state_reg;
        k_next            = k_reg;
        c_next            = c_reg;
        ph_next           = ph_reg;
        result_valid_next = result_valid_reg & result_stall;
        result_next       = result_reg;
        acc_we            = 1'b0;
        wc_we             = 1'b0;
        len_we            = 1'b0;
        scale_we          = 1'b0;
        bound_we          = 1'b0;
        plane_we          = 1'b0;
        plane_wdata       = '0;
        lod_we            = 1'b0;
        sph_we            = 1'b0;
        row_we            = 1'b0;
        cfg_we            = 1'b0;
        sqrt_start        = 1'b0;
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                k_next  = '0;
                c_next  = '0;
                ph_next = 1'b0;
                if (cfg_valid)
                begin
                    cfg_we     = 1'b1;
                    state_next = S_BUILD_SQ;
                end
                else if (item_valid)
                begin
                    if (item.mode == MODE_SPHERE)
                    begin
                        sph_we     = 1'b1;
                        state_next = S_WORLD;
                    end
                    else
                    begin
                        row_we = 1'b1;
                    end
                end
            end

            S_BUILD_SQ, S_SCALE_SQ:
            begin
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    acc_we  = 1'b1;
                    ph_next = 1'b0;
                    if (c_reg == 2'd2)
                    begin
                        c_next     = '0;
                        state_next = (state_reg == S_BUILD_SQ) ? S_BUILD_SQRT : S_SCALE_SQRT;
                    end
                    else
                        c_next = c_reg + 2'd1;
                end
            end

            S_BUILD_SQRT, S_SCALE_SQRT:
            begin
                if (!ph_reg)
                begin
                    sqrt_start = 1'b1;
                    ph_next    = 1'b1;
                end
                else if (sqrt_done)
                begin
                    ph_next = 1'b0;
                    if (state_reg == S_BUILD_SQRT)
                    begin
                        len_we     = 1'b1;
                        state_next = S_BUILD_DIV;
                    end
                    else
                    begin
                        scale_we   = 1'b1;
                        state_next = S_BOUND;
                    end
                end
            end

            S_BUILD_DIV:
            begin
                if (!ph_reg)
                begin
                    if (len_reg == '0)
                    begin
                        // degenerate normal: the whole plane is zero
                        plane_we = 1'b1;
                        col_done = 1'b1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        ph_next   = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    plane_we    = 1'b1;
                    plane_wdata = norm;
                    ph_next     = 1'b0;
                    col_done    = 1'b1;
                end
                if (col_done)
                begin
                    if (c_reg == 2'd3)
                    begin
                        c_next = '0;
                        if (k_reg == 3'd5)
                            state_next = S_IDLE;
                        else
                        begin
                            k_next     = k_reg + 3'd1;
                            state_next = S_BUILD_SQ;
                        end
                    end
                    else
                        c_next = c_reg + 2'd1;
                end
            end

            S_WORLD:
            begin
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    acc_we  = 1'b1;
                    ph_next = 1'b0;
                    if (c_reg == 2'd2)
                    begin
                        wc_we  = 1'b1;
                        c_next = '0;
                        if (k_reg == 3'd2)
                        begin
                            k_next     = '0;
                            state_next = S_SCALE_SQ;
                        end
                        else
                            k_next = k_reg + 3'd1;
                    end
                    else
                        c_next = c_reg + 2'd1;
                end
            end

            S_BOUND:
            begin
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    bound_we   = 1'b1;
                    ph_next    = 1'b0;
                    k_next     = '0;
                    c_next     = '0;
                    state_next = S_PLANE;
                end
            end

            S_PLANE:
            begin
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    acc_we  = 1'b1;
                    ph_next = 1'b0;
                    if (c_reg == 2'd3)
                    begin
                        c_next = '0;
                        if (culled)
                            state_next = S_IDLE;
                        else if (k_reg == 3'd5)
                        begin
                            k_next     = '0;
                            state_next = S_DEPTH;
                        end
                        else
                            k_next = k_reg + 3'd1;
                    end
                    else
                        c_next = c_reg + 2'd1;
                end
            end

            S_DEPTH:
            begin
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    acc_we  = 1'b1;
                    ph_next = 1'b0;
                    if (c_reg == 2'd3)
                    begin
                        lod_we     = 1'b1;
                        c_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                        c_next = c_reg + 2'd1;
                end
            end

            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next     = 1'b1;
                    result_next.visible_id = id_reg & id_mask;
                    result_next.lod_level  = lod_reg;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_BUILD_SQ;
            k_reg            <= '0;
            c_reg            <= '0;
            ph_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            c_reg            <= c_next;
            ph_reg           <= ph_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // matrix and model rows come up as identity / zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                vp_reg[i] <= '0;
            vp_reg[0] <= {32'h0, ONE};
            vp_reg[2] <= {ONE, 32'h0};
            vp_reg[5] <= {32'h0, ONE};
            vp_reg[7] <= {ONE, 32'h0};
            for (int i = 0; i < 12; i++)
                mrow_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                vp_reg[cfg_index] <= cfg_data;
            if (row_we)
            begin
                mrow_reg[{item.mode, 2'd0}] <= item.val_a;
                mrow_reg[{item.mode, 2'd1}] <= item.val_b;
                mrow_reg[{item.mode, 2'd2}] <= item.val_c;
                mrow_reg[{item.mode, 2'd3}] <= item.val_d;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_reg <= acc_sum;
        if (wc_we)
            wc_reg[k_reg[1:0]] <= s_sat;
        if (len_we)
            len_reg <= sqrt_root;
        if (scale_we)
            scale_reg <= sqrt_root[31] ? 32'h7fff_ffff : sqrt_root;
        if (bound_we)
            bound_reg <= s_sat;
        if (plane_we)
            plane_reg[{k_reg, c_reg}] <= plane_wdata;
        if (lod_we)
            lod_reg <= lod_calc;
        if (sph_we)
        begin
            sph_reg[0] <= item.val_a;
            sph_reg[1] <= item.val_b;
            sph_reg[2] <= item.val_c;
            sph_reg[3] <= item.val_d;
            id_reg     <= item.object_id;
        end
    end

    assign item_stall   = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_sphere_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.mode == MODE_SPHERE |=> item_stall)
        else $error("sphere transfer did not start the test sequence");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cfg_ready && item_stall)
        else $error("register write did not start a plane rebuild");

    a_plane_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLANE || state_reg == S_BUILD_DIV) |-> k_reg <= 3'd5)
        else $error("plane index out of range");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule
`default_nettype wire

### rtl/sfc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sfc_mul
    import sfc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [OPND_W-1:0] opnd_a,
    input  wire logic signed [OPND_W-1:0] opnd_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= opnd_a * opnd_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

### rtl/sfc_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_sqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sfc_sqrt
    import sfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] rem_reg;
    logic [RAD_W-1:0] root_reg;
    logic [RAD_W-1:0] bit_reg;
    logic [RAD_W-1:0] trial;
    logic             take;

    assign trial = root_reg + bit_reg;
    assign take  = (rem_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg <= ~bit_reg[0];
            done_reg <= bit_reg[0];
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule
`default_nettype wire

### rtl/sfc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfc_div
    import sfc_pkg::*;
#(
    parameter int DVD_W = 32 + DEF_FRAC_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [31:0]       divisor,
    output logic                   done,
    output logic [DVD_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [31:0]      rem_reg;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             take;

    // quo_reg shifts the dividend out at the top and the quotient in at the bottom
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign take  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], take};
            rem_reg <= take ? diff[31:0] : trial[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire
